### design/lts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lts_pkg: shared definitions for the S-expression token scanner
// Token kinds, token and push records, ASCII codes and sizing constants.
// ----------------------------------------------------------------------------
package lts_pkg;

    // Default width of the number accumulator.
    localparam int VALUE_BITS_DEF = 32;

    // Fixed widths of the token fields.
    localparam int NUM_W  = 32;
    localparam int CHAR_W = 8;
    localparam int KIND_W = 4;

    // Token queue sizing; the depth is a power of two so the pointers wrap.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // ASCII codes with a meaning of their own.
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // Token kind codes as seen on the output port.
    typedef enum logic [KIND_W-1:0] {
        KIND_SPACE       = 4'd0,
        KIND_OPEN_PAREN  = 4'd1,
        KIND_CLOSE_PAREN = 4'd2,
        KIND_OPEN_BRACK  = 4'd3,
        KIND_CLOSE_BRACK = 4'd4,
        KIND_NUMBER      = 4'd5,
        KIND_CHAR        = 4'd6,
        KIND_SYMBOL      = 4'd7,
        KIND_INVALID     = 4'd8
    } t_kind;

    // One result token.
    typedef struct packed {
        t_kind             kind;
        logic [NUM_W-1:0]  number;
        logic [CHAR_W-1:0] chr;
        logic              last;
    } t_token;

    // Tokens produced by one input byte, handed to the queue.
    typedef struct packed {
        logic [1:0] cnt;
        t_token     tok0;
        t_token     tok1;
    } t_push;

endpackage

### design/lts_scan_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lts_scan_core: input register and scanner state update
// Holds one input byte, classifies it against the scan mode and the digit
// accumulator, and produces zero, one or two tokens per byte.
// ----------------------------------------------------------------------------
module lts_scan_core #(
    parameter int VALUE_BITS = lts_pkg::VALUE_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [7:0]    i_in_byte,
    input  logic          i_end_of_input,
    input  logic          i_room,
    output lts_pkg::t_push o_push,
    output logic          o_halted
);
    import lts_pkg::*;

    localparam int ACC_W = VALUE_BITS + 4;

    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_LETTERS = 5'b00010,
        MODE_DIGITS  = 5'b00100,
        MODE_ESCAPE  = 5'b01000,
        MODE_HALTED  = 5'b10000
    } t_mode;

    logic                  r_in_valid, n_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_in_eoi;
    t_mode                 r_mode, n_mode;
    logic [VALUE_BITS-1:0] r_accum, n_accum;

    logic                  accept;
    logic                  fire;
    logic                  b_blank, b_letter, b_digit, b_term;
    logic [3:0]            digit;
    logic [ACC_W-1:0]      acc_x10;
    logic [VALUE_BITS-1:0] acc_next;
    logic                  cls_emit;
    t_kind                 cls_kind;
    t_mode                 cls_mode;
    logic [VALUE_BITS-1:0] cls_accum;
    t_token                tok0, tok1;
    logic [1:0]            cnt;

    function automatic t_token make_tok(t_kind kind, logic [NUM_W-1:0] num,
                                        logic [CHAR_W-1:0] chr);
        t_token t;
        t.kind   = kind;
        t.number = num;
        t.chr    = chr;
        t.last   = 1'b0;
        return t;
    endfunction

    // Handshake: the held byte moves on whenever the queue has room for two tokens.
    assign fire    = r_in_valid && i_room;
    assign o_stall = r_in_valid && !i_room;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (accept) begin
            n_in_valid = 1'b1;
        end else if (fire) begin
            n_in_valid = 1'b0;
        end
    end

    // Byte classes.
    assign b_blank  = (r_in_byte == 8'h20) || (r_in_byte >= 8'h09 && r_in_byte <= 8'h0D);
    assign b_letter = (r_in_byte >= 8'h41 && r_in_byte <= 8'h5A)
                   || (r_in_byte >= 8'h61 && r_in_byte <= 8'h7A);
    assign b_digit  = (r_in_byte >= 8'h30 && r_in_byte <= 8'h39);
    assign b_term   = b_blank || (r_in_byte == CH_LPAREN) || (r_in_byte == CH_RPAREN);
    assign digit    = r_in_byte[3:0];

    // Accumulate a digit as 8a + 2a + d; any carry above the value width saturates.
    assign acc_x10  = (ACC_W'(r_accum) << 3) + (ACC_W'(r_accum) << 1) + ACC_W'(digit);
    assign acc_next = (|acc_x10[ACC_W-1:VALUE_BITS]) ? {VALUE_BITS{1'b1}}
                                                      : acc_x10[VALUE_BITS-1:0];

    // Classification of a byte seen with no run open.
    always_comb begin
        cls_emit  = 1'b1;
        cls_kind  = KIND_SYMBOL;
        cls_mode  = MODE_IDLE;
        cls_accum = r_accum;
        if (b_blank || r_in_byte == CH_COMMA) begin
            cls_kind = KIND_SPACE;
        end else if (b_letter) begin
            cls_emit = 1'b0;
            cls_mode = MODE_LETTERS;
        end else if (b_digit) begin
            cls_emit  = 1'b0;
            cls_mode  = MODE_DIGITS;
            cls_accum = VALUE_BITS'(digit);
        end else begin
            case (r_in_byte)
                CH_LPAREN: cls_kind = KIND_OPEN_PAREN;
                CH_RPAREN: cls_kind = KIND_CLOSE_PAREN;
                CH_LBRACK: cls_kind = KIND_OPEN_BRACK;
                CH_RBRACK: cls_kind = KIND_CLOSE_BRACK;
                CH_BSLASH: begin
                    cls_emit = 1'b0;
                    cls_mode = MODE_ESCAPE;
                end
                default:   cls_kind = KIND_SYMBOL;
            endcase
        end
    end

    // Scan step: next mode, next accumulator and the tokens of this byte.
    always_comb begin
        n_mode  = r_mode;
        n_accum = r_accum;
        cnt     = 2'd0;
        tok0    = make_tok(KIND_SPACE, '0, '0);
        tok1    = make_tok(KIND_SPACE, '0, '0);
        if (fire) begin
            case (r_mode)
                MODE_HALTED: begin
                    n_mode = MODE_HALTED;
                end
                MODE_LETTERS: begin
                    if (r_in_eoi) begin
                        tok0   = make_tok(KIND_SYMBOL, '0, '0);
                        cnt    = 2'd1;
                        n_mode = MODE_IDLE;
                    end else if (!b_letter) begin
                        tok0    = make_tok(KIND_SYMBOL, '0, '0);
                        tok1    = make_tok(cls_kind, '0, '0);
                        cnt     = cls_emit ? 2'd2 : 2'd1;
                        n_mode  = cls_mode;
                        n_accum = cls_accum;
                    end
                end
                MODE_DIGITS: begin
                    if (r_in_eoi) begin
                        tok0   = make_tok(KIND_INVALID, '0, '0);
                        cnt    = 2'd1;
                        n_mode = MODE_HALTED;
                    end else if (b_digit) begin
                        n_accum = acc_next;
                    end else if (b_term) begin
                        // A terminator always yields its own token after the number.
                        tok0    = make_tok(KIND_NUMBER, NUM_W'(r_accum), '0);
                        tok1    = make_tok(cls_kind, '0, '0);
                        cnt     = 2'd2;
                        n_mode  = MODE_IDLE;
                        n_accum = '0;
                    end else begin
                        tok0    = make_tok(KIND_INVALID, '0, '0);
                        cnt     = 2'd1;
                        n_mode  = MODE_HALTED;
                        n_accum = '0;
                    end
                end
                MODE_ESCAPE: begin
                    tok0   = make_tok(KIND_CHAR, '0, r_in_eoi ? 8'h00 : r_in_byte);
                    cnt    = 2'd1;
                    n_mode = MODE_IDLE;
                end
                default: begin
                    n_mode = MODE_IDLE;
                    if (!r_in_eoi) begin
                        n_mode  = cls_mode;
                        n_accum = cls_accum;
                        if (cls_emit) begin
                            tok0 = make_tok(cls_kind, '0, '0);
                            cnt  = 2'd1;
                        end
                    end
                end
            endcase
        end
        // Mark the final token of this byte.
        if (cnt == 2'd1) begin
            tok0.last = 1'b1;
        end
        if (cnt == 2'd2) begin
            tok1.last = 1'b1;
        end
    end

    assign o_push.cnt  = cnt;
    assign o_push.tok0 = tok0;
    assign o_push.tok1 = tok1;
    assign o_halted    = (r_mode == MODE_HALTED);

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= MODE_IDLE;
            r_accum    <= '0;
        end else begin
            r_in_valid <= n_in_valid;
            r_mode     <= n_mode;
            r_accum    <= n_accum;
        end
    end

    // Input payload register.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_in_byte;
            r_in_eoi  <= i_end_of_input;
        end
    end

endmodule

### design/lts_tok_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lts_tok_queue: result token queue
// Takes up to two tokens per cycle from the scanner, which pushes only while
// two slots are free, and hands out one token per output transfer.
// ----------------------------------------------------------------------------
module lts_tok_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lts_pkg::t_push i_push,
    output logic           o_room,
    output logic           o_valid,
    input  logic           i_stall,
    output lts_pkg::t_token o_token
);
    import lts_pkg::*;

    t_token              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]   r_count, n_count;
    logic                pop;

    assign o_valid = (r_count != '0);
    assign pop     = o_valid && !i_stall;
    assign o_room  = (r_count <= QCNT_W'(QUEUE_DEPTH - 2));
    assign o_token = r_mem[r_rd_ptr];

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr + QPTR_W'(i_push.cnt);
        n_rd_ptr = r_rd_ptr + QPTR_W'(pop);
        n_count  = r_count + QCNT_W'(i_push.cnt) - QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Token storage; the second token goes to the slot after the first.
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.tok0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wr_ptr + QPTR_W'(1)] <= i_push.tok1;
        end
    end

endmodule

### design/lisp_token_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lisp_token_scanner: byte-serial S-expression tokenizer
// Top level: scanner core followed by a four-entry token queue.
// ----------------------------------------------------------------------------
// The scanner takes one source byte, or an end-of-input mark, per transfer and
// accepts a new one every clock while the token queue has two free slots. A
// byte reaches the input register on its transfer, and its tokens go from that
// register into the queue once the queue has room. The output hands out one
// token per cycle while it is not stalled; a byte that closes a run and is
// itself a token produces two, so a text dense in such bytes is limited by the
// output side. After an invalid number the scanner halts, consumes further
// bytes without producing tokens, and needs a reset.
module lisp_token_scanner #(
    parameter int VALUE_BITS = lts_pkg::VALUE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_input,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [3:0] o_token_kind,
    output logic [31:0] o_number_value,
    output logic [7:0] o_char_value,
    output logic       o_last_of_run
);
    import lts_pkg::*;

    t_push  push;
    t_token token;
    logic   room;
    logic   halted;

    // Scanner state and input register.
    lts_scan_core #(
        .VALUE_BITS (VALUE_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_in_byte      (i_in_byte),
        .i_end_of_input (i_end_of_input),
        .i_room         (room),
        .o_push         (push),
        .o_halted       (halted)
    );

    // Result token queue.
    lts_tok_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_token (token)
    );

    assign o_token_kind   = token.kind;
    assign o_number_value = token.number;
    assign o_char_value   = token.chr;
    assign o_last_of_run  = token.last;

`ifndef SYNTHESIS
    // A halted scanner never produces tokens.
    a_halted_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        halted |-> (push.cnt == 2'd0))
        else $error("tokens produced while halted");

    // An invalid token always halts the scanner.
    a_invalid_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.cnt != 2'd0 && push.tok0.kind == KIND_INVALID) |=> halted)
        else $error("scanner kept running after an invalid token");

    // Only number tokens carry a value.
    a_number_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_token_kind != KIND_NUMBER) |-> (o_number_value == '0))
        else $error("number value on a token that is not a number");
`endif

endmodule

### dv/token_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// token_checker: transfer monitor and token predictor for the scanner
// Watches the byte and token channels of lisp_token_scanner. For every byte
// transfer it predicts the tokens that follow, and it compares each token
// transfer field by field with the oldest predicted token.
// ----------------------------------------------------------------------------
module token_checker #(
    parameter int VALUE_BITS = lts_pkg::VALUE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_end,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [3:0]  i_token_kind,
    input  logic [31:0] i_number_value,
    input  logic [7:0]  i_char_value,
    input  logic        i_last_of_run,
    output int          o_errors,
    output int          o_pending,
    output int          o_checked
);
    import lts_pkg::*;

    // Byte codes that the package does not name.
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;

    localparam logic [63:0] VALUE_MAX = {64{1'b1}} >> (64 - VALUE_BITS);

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_WORD,
        SCAN_NUMBER,
        SCAN_ESCAPE,
        SCAN_HALTED
    } t_scan;

    t_scan       scan_state;
    logic [63:0] digit_value;
    t_token      step_tokens[$];
    t_token      expected_tokens[$];

    function automatic logic is_blank(logic [7:0] b);
        return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic logic is_letter(logic [7:0] b);
        return (b >= CH_UPPER_A && b <= CH_UPPER_Z) || (b >= CH_LOWER_A && b <= CH_LOWER_Z);
    endfunction

    function automatic logic is_digit(logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function automatic void add_token(t_kind kind, logic [63:0] num, logic [7:0] chr);
        t_token tok;
        tok.kind   = kind;
        tok.number = num[31:0];
        tok.chr    = chr;
        tok.last   = 1'b0;
        step_tokens.push_back(tok);
    endfunction

    // A byte seen while idle either is a token of its own or opens a run.
    function automatic void classify_byte(logic [7:0] b);
        if (is_blank(b) || b == CH_COMMA) begin
            add_token(KIND_SPACE, 64'd0, 8'd0);
        end else if (is_letter(b)) begin
            scan_state = SCAN_WORD;
        end else if (is_digit(b)) begin
            scan_state  = SCAN_NUMBER;
            digit_value = {56'd0, b} - {56'd0, CH_ZERO};
        end else begin
            case (b)
                CH_LPAREN: add_token(KIND_OPEN_PAREN, 64'd0, 8'd0);
                CH_RPAREN: add_token(KIND_CLOSE_PAREN, 64'd0, 8'd0);
                CH_LBRACK: add_token(KIND_OPEN_BRACK, 64'd0, 8'd0);
                CH_RBRACK: add_token(KIND_CLOSE_BRACK, 64'd0, 8'd0);
                CH_BSLASH: scan_state = SCAN_ESCAPE;
                default:   add_token(KIND_SYMBOL, 64'd0, 8'd0);
            endcase
        end
    endfunction

    // Advance the scanner state by one byte or end mark and queue its tokens.
    function automatic void predict_tokens(logic [7:0] b, logic eoi);
        logic [63:0] d;
        t_token      tail;
        step_tokens.delete();
        if (scan_state != SCAN_HALTED) begin
            if (eoi) begin
                case (scan_state)
                    SCAN_WORD:   add_token(KIND_SYMBOL, 64'd0, 8'd0);
                    SCAN_NUMBER: add_token(KIND_INVALID, 64'd0, 8'd0);
                    SCAN_ESCAPE: add_token(KIND_CHAR, 64'd0, 8'd0);
                    default:     ;
                endcase
                scan_state = (scan_state == SCAN_NUMBER) ? SCAN_HALTED : SCAN_IDLE;
            end else begin
                case (scan_state)
                    SCAN_WORD: begin
                        if (!is_letter(b)) begin
                            add_token(KIND_SYMBOL, 64'd0, 8'd0);
                            scan_state = SCAN_IDLE;
                            classify_byte(b);
                        end
                    end
                    SCAN_NUMBER: begin
                        if (is_digit(b)) begin
                            // Saturate instead of wrapping once the value tops out.
                            d = {56'd0, b} - {56'd0, CH_ZERO};
                            if (digit_value > (VALUE_MAX - d) / 64'd10)
                                digit_value = VALUE_MAX;
                            else
                                digit_value = digit_value * 64'd10 + d;
                        end else if (b == CH_LPAREN || b == CH_RPAREN || is_blank(b)) begin
                            add_token(KIND_NUMBER, digit_value, 8'd0);
                            digit_value = 64'd0;
                            scan_state  = SCAN_IDLE;
                            classify_byte(b);
                        end else begin
                            add_token(KIND_INVALID, 64'd0, 8'd0);
                            digit_value = 64'd0;
                            scan_state  = SCAN_HALTED;
                        end
                    end
                    SCAN_ESCAPE: begin
                        add_token(KIND_CHAR, 64'd0, b);
                        scan_state = SCAN_IDLE;
                    end
                    default: begin
                        scan_state = SCAN_IDLE;
                        classify_byte(b);
                    end
                endcase
            end
        end
        if (step_tokens.size() > 0) begin
            tail      = step_tokens.pop_back();
            tail.last = 1'b1;
            step_tokens.push_back(tail);
        end
        foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_val,
                                        logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
            o_errors++;
        end
    endfunction

    // Token transfers are checked before the byte transfer of the same edge
    // is predicted; a byte's tokens never leave in the cycle it arrives.
    always @(posedge i_clk) begin
        t_token exp_tok;
        if (!i_rst_n) begin
            scan_state  = SCAN_IDLE;
            digit_value = 64'd0;
            expected_tokens.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_tokens.size() == 0) begin
                    $error("token transfer with none expected: kind %0d", i_token_kind);
                    o_errors++;
                end else begin
                    exp_tok = expected_tokens.pop_front();
                    check_field("token_kind", 32'(exp_tok.kind), 32'(i_token_kind));
                    check_field("number_value", exp_tok.number, i_number_value);
                    check_field("char_value", 32'(exp_tok.chr), 32'(i_char_value));
                    check_field("last_of_run", 32'(exp_tok.last), 32'(i_last_of_run));
                    o_checked++;
                end
            end
            if (i_in_valid && !i_in_stall) predict_tokens(i_in_byte, i_in_end);
        end
        o_pending = expected_tokens.size();
    end

    initial begin
        o_errors    = 0;
        o_pending   = 0;
        o_checked   = 0;
        scan_state  = SCAN_IDLE;
        digit_value = 64'd0;
    end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the S-expression token scanner
// Drives directed and random source text into lisp_token_scanner with random
// gaps on the byte side and random stalls on the token side. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import lts_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 1550;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_VT      = 8'h0B;
    localparam logic [7:0] CH_FF      = 8'h0C;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic [7:0]  i_in_byte      = 8'd0;
    logic        i_end_of_input = 1'b0;
    logic        i_stall        = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [3:0]  o_token_kind;
    logic [31:0] o_number_value;
    logic [7:0]  o_char_value;
    logic        o_last_of_run;

    logic        quiet       = 1'b0;
    int          cycle_count = 0;
    int          items_sent  = 0;
    int          errors;
    int          pending;
    int          checked;
    string       halt_cause;

    lisp_token_scanner dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_in_byte      (i_in_byte),
        .i_end_of_input (i_end_of_input),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_token_kind   (o_token_kind),
        .o_number_value (o_number_value),
        .o_char_value   (o_char_value),
        .o_last_of_run  (o_last_of_run)
    );

    token_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_in_byte      (i_in_byte),
        .i_in_end       (i_end_of_input),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_token_kind   (o_token_kind),
        .i_number_value (o_number_value),
        .i_char_value   (o_char_value),
        .i_last_of_run  (o_last_of_run),
        .o_errors       (errors),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    always #1 i_clk = ~i_clk;

    // Random stalls on the token side, none during the quiet window.
    always @(posedge i_clk) begin
        i_stall <= !quiet && ($urandom_range(99) < 6);
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // One byte transfer, with random gap cycles in front of it.
    task automatic send_item(input logic [7:0] b, input logic eoi);
        while (!quiet && $urandom_range(99) < 6) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_in_byte      <= b;
        i_end_of_input <= eoi;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
    endtask

    // Blanks first, then the parentheses, then the bytes that cannot end a number.
    function automatic logic [7:0] pick_delimiter(int unsigned k);
        case (k)
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_LF;
            3:       return CH_VT;
            4:       return CH_FF;
            5:       return CH_CR;
            6:       return CH_LPAREN;
            7:       return CH_RPAREN;
            8:       return CH_COMMA;
            9:       return CH_LBRACK;
            default: return CH_RBRACK;
        endcase
    endfunction

    function automatic logic [7:0] random_letter();
        logic [7:0] base;
        base = $urandom_range(1) ? CH_UPPER_A : CH_LOWER_A;
        return base + 8'($urandom_range(25));
    endfunction

    task automatic send_digits(input int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            send_item(CH_ZERO + 8'($urandom_range(9)), 1'b0);
    endtask

    // A chunk of well-formed text; no chunk leaves a number or an escape open,
    // so the scanner never halts before the final part of the run.
    task automatic send_random_chunk();
        int unsigned pick;
        logic [7:0]  b;
        pick = $urandom_range(99);
        if (pick < 20) begin
            repeat ($urandom_range(8, 1)) send_item(random_letter(), 1'b0);
        end else if (pick < 45) begin
            // Mostly short numbers, a few long enough to saturate.
            if ($urandom_range(99) < 15) send_digits($urandom_range(13, 9));
            else                         send_digits($urandom_range(4, 1));
            send_item(pick_delimiter($urandom_range(7)), 1'b0);
        end else if (pick < 55) begin
            send_item(CH_BSLASH, 1'b0);
            if ($urandom_range(9) == 0) send_item(8'($urandom_range(255)), 1'b1);
            else                        send_item(8'($urandom_range(255)), 1'b0);
        end else if (pick < 60) begin
            send_item(8'($urandom_range(255)), 1'b1);
        end else if (pick < 80) begin
            send_item(pick_delimiter($urandom_range(10)), 1'b0);
        end else begin
            b = 8'($urandom_range(255));
            while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_BSLASH)
                b = 8'($urandom_range(255));
            send_item(b, 1'b0);
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every delimiter, a word closed by a parenthesis, a saturating
        // number, escapes, and end of input after an escape, in a word and when idle.
        send_string("()[] ,");
        send_item(CH_TAB, 1'b0);
        send_item(CH_LF, 1'b0);
        send_item(CH_VT, 1'b0);
        send_item(CH_FF, 1'b0);
        send_item(CH_CR, 1'b0);
        send_string("aZ(");
        send_string("5000000000(");
        send_item(CH_BSLASH, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(CH_BSLASH, 1'b0);
        send_item(8'h00, 1'b1);
        send_item(CH_LOWER_A, 1'b0);
        send_item(8'h7F, 1'b1);
        send_item(8'h80, 1'b0);
        send_item(8'hAA, 1'b1);

        // Random text, with a window free of gaps and stalls.
        while (items_sent < RANDOM_ITEMS) begin
            quiet <= (items_sent >= 600 && items_sent < 900);
            send_random_chunk();
        end
        quiet <= 1'b0;

        // A number with a bad terminator halts the scanner; later bytes are dropped.
        send_digits($urandom_range(3, 1));
        case ($urandom_range(3))
            0: begin
                halt_cause = "end of input";
                send_item(8'($urandom_range(255)), 1'b1);
            end
            1: begin
                halt_cause = "comma";
                send_item(CH_COMMA, 1'b0);
            end
            2: begin
                halt_cause = "bracket";
                send_item(pick_delimiter($urandom_range(10, 9)), 1'b0);
            end
            default: begin
                halt_cause = "letter";
                send_item(random_letter(), 1'b0);
            end
        endcase
        send_item(CH_SPACE, 1'b0);
        send_item(CH_ZERO, 1'b0);
        send_item(CH_LPAREN, 1'b0);
        send_item(8'h00, 1'b1);
        i_valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);

        $display("Covered %0d byte and end-of-input transfers and %0d compared tokens.",
                 items_sent, checked);
        $display("The scanner was halted by a number ended with %s.", halt_cause);
        if (errors == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
